// ===== design/button_debounce_long_press_defines.svh =====
// Assertion macros for the button debounce block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_DEFINES_SVH

// same-cycle implication
`define BDLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bdlp_pkg.sv =====
// Shared types and constants for the button debounce block.
// No dependencies; used by bdlp_in_if and every module.
package bdlp_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned CfgW  = 16;

  localparam logic [CfgW-1:0] DebounceReset  = 16'd40;
  localparam logic [CfgW-1:0] LongPressReset = 16'd700;

  typedef enum logic {
    CfgDebounce  = 1'b0,
    CfgLongPress = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [TimeW-1:0] now_ms;
    logic             edge_seen;
    logic             raw_pressed;
  } item_t;

  typedef struct packed {
    logic short_press;
    logic long_press;
    logic stable_level;
  } result_t;

endpackage

// ===== design/bdlp_in_if.sv =====
// Request channel carrying one service tick.
// Depends on bdlp_pkg for the timestamp width.
interface bdlp_in_if;
  import bdlp_pkg::*;

  logic             valid;
  logic             ready;
  logic [TimeW-1:0] now_ms;
  logic             edge_seen;
  logic             raw_pressed;

  modport source (output valid, now_ms, edge_seen, raw_pressed, input ready);
  modport sink   (input valid, now_ms, edge_seen, raw_pressed, output ready);
endinterface

// ===== design/bdlp_out_if.sv =====
// Result channel carrying press events and the debounced level.
// Depends on nothing outside this file.
interface bdlp_out_if;
  logic valid;
  logic ready;
  logic short_press;
  logic long_press;
  logic stable_level;

  modport source (output valid, short_press, long_press, stable_level, input ready);
  modport sink   (input valid, short_press, long_press, stable_level, output ready);
endinterface

// ===== design/bdlp_in_stage.sv =====
// Input register stage: holds one request until the core takes it.
// Depends on bdlp_pkg.
module bdlp_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  bdlp_pkg::item_t req_item_i,
  input  logic            take_i,
  output logic            valid_o,
  output bdlp_pkg::item_t item_o
);
  import bdlp_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  assign req_ready_o = !valid_q || take_i;
  assign load        = req_valid_i && req_ready_o;

  always_comb begin
    priority if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= req_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
endmodule

// ===== design/bdlp_core.sv =====
// Debounce and press-timing state with its update logic.
// Depends on bdlp_pkg; holds the configuration registers.
module bdlp_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  bdlp_pkg::cfg_idx_e    cfg_idx_i,
  input  logic [bdlp_pkg::CfgW-1:0] cfg_wdata_i,
  input  logic                  step_i,
  input  bdlp_pkg::item_t       item_i,
  output bdlp_pkg::result_t     result_o
);
  import bdlp_pkg::*;

  logic [CfgW-1:0]  debounce_q, long_time_q;
  logic             armed_q, armed_d;
  logic [TimeW-1:0] last_edge_q, last_edge_d;
  logic             stable_q, stable_d;
  logic [TimeW-1:0] press_start_q, press_start_d;
  logic             long_rep_q, long_rep_d;

  logic             armed_e;
  logic             settled;
  logic             lr_mid;
  logic             long_evt;
  logic             short_evt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q  <= DebounceReset;
      long_time_q <= LongPressReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgDebounce:  debounce_q  <= cfg_wdata_i;
        CfgLongPress: long_time_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    armed_e       = armed_q || item_i.edge_seen;
    last_edge_d   = item_i.edge_seen ? item_i.now_ms : last_edge_q;
    settled       = armed_e &&
                    ((item_i.now_ms - last_edge_d) >= {{(TimeW-CfgW){1'b0}}, debounce_q});
    armed_d       = armed_e;
    stable_d      = stable_q;
    press_start_d = press_start_q;
    lr_mid        = long_rep_q;
    short_evt     = 1'b0;
    if (settled && (item_i.raw_pressed != stable_q)) begin
      stable_d = item_i.raw_pressed;
      if (item_i.raw_pressed) begin
        press_start_d = item_i.now_ms;
        lr_mid        = 1'b0;
      end else begin
        short_evt = !long_rep_q;
        armed_d   = 1'b0;
      end
    end
    long_evt   = settled && stable_d && !lr_mid &&
                 ((item_i.now_ms - press_start_d) >=
                  {{(TimeW-CfgW){1'b0}}, long_time_q});
    long_rep_d = lr_mid || long_evt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q       <= 1'b0;
      last_edge_q   <= '0;
      stable_q      <= 1'b0;
      press_start_q <= '0;
      long_rep_q    <= 1'b0;
    end else if (step_i) begin
      armed_q       <= armed_d;
      last_edge_q   <= last_edge_d;
      stable_q      <= stable_d;
      press_start_q <= press_start_d;
      long_rep_q    <= long_rep_d;
    end
  end

  assign result_o.short_press  = short_evt;
  assign result_o.long_press   = long_evt;
  assign result_o.stable_level = stable_d;
endmodule

// ===== design/bdlp_out_stage.sv =====
// Result register: holds one result until the sink takes it.
// Depends on bdlp_pkg.
module bdlp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  bdlp_pkg::result_t result_i,
  output logic              free_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output bdlp_pkg::result_t result_o
);
  import bdlp_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  assign free_o = !valid_q || rsp_ready_i;

  always_comb begin
    priority if (load_i) begin
      valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign rsp_valid_o = valid_q;
  assign result_o    = result_q;
endmodule

// ===== design/button_debounce_long_press.sv =====
// Top level of the debounced button with short and long press detection.
// Depends on bdlp_pkg, bdlp_in_if, bdlp_out_if, the three stage modules and the defines.
//
//   channel   direction  handshake        payload
//   req_i     in         valid / ready    now_ms, edge_seen, raw_pressed
//   rsp_o     out        valid / ready    short_press, long_press, stable_level
//   cfg       in         cfg_we_i         cfg_idx_i, cfg_wdata_i (16 bit)
//
// One request per cycle unless rsp_o stalls; a taken request is registered in u_in,
// then its result in u_out. The rate is set by the single state update in bdlp_core.
// Reset clears the press state and loads 40 ms debounce and 700 ms long press.
// A stalled result holds; one more request is taken behind it, then ready drops.
`include "button_debounce_long_press_defines.svh"
module button_debounce_long_press (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  bdlp_in_if.sink                   req_i,
  bdlp_out_if.source                rsp_o,
  input  logic                      cfg_we_i,
  input  bdlp_pkg::cfg_idx_e        cfg_idx_i,
  input  logic [bdlp_pkg::CfgW-1:0] cfg_wdata_i
);
  import bdlp_pkg::*;

  item_t   req_item;
  item_t   s1_item;
  logic    s1_valid;
  logic    out_free;
  logic    step;
  result_t core_result;
  result_t rsp_result;

  assign req_item.now_ms      = req_i.now_ms;
  assign req_item.edge_seen   = req_i.edge_seen;
  assign req_item.raw_pressed = req_i.raw_pressed;

  assign step = s1_valid && out_free;

  bdlp_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_item_i  (req_item),
    .take_i      (step),
    .valid_o     (s1_valid),
    .item_o      (s1_item)
  );

  bdlp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .item_i      (s1_item),
    .result_o    (core_result)
  );

  bdlp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .result_i    (core_result),
    .free_o      (out_free),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .result_o    (rsp_result)
  );

  assign rsp_o.short_press  = rsp_result.short_press;
  assign rsp_o.long_press   = rsp_result.long_press;
  assign rsp_o.stable_level = rsp_result.stable_level;

  `BDLP_ASSERT_NOW(a_events_exclusive, rsp_o.valid, !(rsp_o.short_press && rsp_o.long_press), "short and long press in one result")
  `BDLP_ASSERT_NOW(a_short_released, rsp_o.valid && rsp_o.short_press, !rsp_o.stable_level, "short press while level pressed")
  `BDLP_ASSERT_NOW(a_long_pressed, rsp_o.valid && rsp_o.long_press, rsp_o.stable_level, "long press while level released")
  `BDLP_ASSERT_NEXT(a_stage_holds, s1_valid && !out_free, s1_valid, "request dropped while result stalled")

endmodule
